>>> src/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition is followed by another in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/tlpp_pkg.sv
// Shared types and constants of the tilted lidar point projection.
package tlpp_pkg;

    localparam int ANG_W         = 24;
    localparam int TRIG_W        = 32;
    localparam int COORD_W       = 17;
    localparam int MAX_BEAMS_DEF = 1024;
    localparam int N_TERMS       = 5;
    localparam int SIN_LAT       = 3 + 2 * N_TERMS + 1;
    localparam int ROT_LAT       = 8;

    localparam logic [32:0]      TWO_PI_Q30 = 33'd6746518852;
    localparam logic [30:0]      ONE_Q30    = 31'h4000_0000;
    localparam logic [ANG_W-1:0] QUARTER    = 24'h40_0000;

    // Horner divisors 110, 72, 42, 20, 6 as exact reciprocal multiply and shift
    localparam int DIV_SH [N_TERMS] = '{39, 39, 38, 37, 35};
    localparam logic [32:0] DIV_M [N_TERMS] = '{
        33'(((64'd1 << 39) + 64'd109) / 64'd110),
        33'(((64'd1 << 39) + 64'd71) / 64'd72),
        33'(((64'd1 << 38) + 64'd41) / 64'd42),
        33'(((64'd1 << 37) + 64'd19) / 64'd20),
        33'(((64'd1 << 35) + 64'd5) / 64'd6)
    };

    typedef struct packed {
        logic [23:0] start_angle;
        logic [23:0] angle_step;
        logic [15:0] pan_offset;
        logic [15:0] tilt_angle;
        logic [15:0] intensity_floor;
        logic [23:0] intensity_gain;
    } t_cfg;

endpackage

>>> src/tlpp_apb.sv
// Configuration register bank with its APB-style access port.
module tlpp_apb (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tlpp_pkg::t_cfg      o_cfg
);

    typedef enum logic [2:0] {
        REG_START_ANGLE,
        REG_ANGLE_STEP,
        REG_PAN_OFFSET,
        REG_TILT_ANGLE,
        REG_INT_FLOOR,
        REG_INT_GAIN
    } t_reg_idx;

    tlpp_pkg::t_cfg r_cfg;
    t_reg_idx       w_idx;
    logic           w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;

    // Write registers on the access phase; drop writes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_angle     <= 24'd0;
            r_cfg.angle_step      <= 24'd16384;
            r_cfg.pan_offset      <= 16'd30037;
            r_cfg.tilt_angle      <= 16'hEAAB;
            r_cfg.intensity_floor <= 16'd2000;
            r_cfg.intensity_gain  <= 24'd8389;
        end else if (w_wr) begin
            case (w_idx)
                REG_START_ANGLE: r_cfg.start_angle     <= pwdata[23:0];
                REG_ANGLE_STEP:  r_cfg.angle_step      <= pwdata[23:0];
                REG_PAN_OFFSET:  r_cfg.pan_offset      <= pwdata[15:0];
                REG_TILT_ANGLE:  r_cfg.tilt_angle      <= pwdata[15:0];
                REG_INT_FLOOR:   r_cfg.intensity_floor <= pwdata[15:0];
                REG_INT_GAIN:    r_cfg.intensity_gain  <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    // Return register contents on reads
    always_comb begin
        case (w_idx)
            REG_START_ANGLE: prdata = {8'd0, r_cfg.start_angle};
            REG_ANGLE_STEP:  prdata = {8'd0, r_cfg.angle_step};
            REG_PAN_OFFSET:  prdata = {16'd0, r_cfg.pan_offset};
            REG_TILT_ANGLE:  prdata = {16'd0, r_cfg.tilt_angle};
            REG_INT_FLOOR:   prdata = {16'd0, r_cfg.intensity_floor};
            REG_INT_GAIN:    prdata = {8'd0, r_cfg.intensity_gain};
            default:         prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/tlpp_sin.sv
// Pipelined Q30 sine of a 24-bit binary angle, Taylor series in Horner form.
module tlpp_sin (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [tlpp_pkg::ANG_W-1:0]      i_angle,
    output logic signed [tlpp_pkg::TRIG_W-1:0] o_sin
);

    localparam int N = tlpp_pkg::N_TERMS;

    logic [22:0] n_u;
    logic [22:0] r_u;
    logic        r_neg0;
    logic [55:0] w_xp;
    logic [30:0] r_x1;
    logic        r_neg1;
    logic [61:0] w_x2p;
    logic [31:0] r_x2;
    logic [30:0] r_x2c;
    logic        r_neg2;

    logic [31:0] r_pa  [N];
    logic [30:0] r_xa  [N];
    logic [31:0] r_x2a [N];
    logic        r_nga [N];
    logic [30:0] r_tb  [N];
    logic [30:0] r_xb  [N];
    logic [31:0] r_x2b [N];
    logic        r_ngb [N];

    logic [30:0] w_tin  [N];
    logic [30:0] w_xin  [N];
    logic [31:0] w_x2in [N];
    logic        w_ngin [N];
    logic [62:0] w_pp   [N];
    logic [64:0] w_qp   [N];

    logic [61:0] w_sp;
    logic signed [tlpp_pkg::TRIG_W-1:0] r_sin;

    // Fold the angle into the first quarter
    always_comb begin
        n_u = {1'b0, i_angle[21:0]};
        if (i_angle[22]) begin
            n_u = {1'b1, 22'd0} - {1'b0, i_angle[21:0]};
        end
    end

    assign w_xp  = 56'(r_u) * 56'(tlpp_pkg::TWO_PI_Q30);
    assign w_x2p = 62'(r_x1) * 62'(r_x1);

    // Residue, radians, radians squared
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u    <= n_u;
            r_neg0 <= i_angle[23];
            r_x1   <= w_xp[54:24];
            r_neg1 <= r_neg0;
            r_x2   <= w_x2p[61:30];
            r_x2c  <= r_x1;
            r_neg2 <= r_neg1;
        end
    end

    // One Horner term per two stages: product, then divide and subtract
    for (genvar i = 0; i < N; i++) begin : g_term
        if (i == 0) begin : g_first
            assign w_tin[i]  = tlpp_pkg::ONE_Q30;
            assign w_xin[i]  = r_x2c;
            assign w_x2in[i] = r_x2;
            assign w_ngin[i] = r_neg2;
        end else begin : g_next
            assign w_tin[i]  = r_tb[i-1];
            assign w_xin[i]  = r_xb[i-1];
            assign w_x2in[i] = r_x2b[i-1];
            assign w_ngin[i] = r_ngb[i-1];
        end

        assign w_pp[i] = 63'(w_x2in[i]) * 63'(w_tin[i]);
        assign w_qp[i] = 65'(r_pa[i]) * 65'(tlpp_pkg::DIV_M[i]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pa[i]  <= w_pp[i][61:30];
                r_xa[i]  <= w_xin[i];
                r_x2a[i] <= w_x2in[i];
                r_nga[i] <= w_ngin[i];
                r_tb[i]  <= tlpp_pkg::ONE_Q30 - 31'(w_qp[i] >> tlpp_pkg::DIV_SH[i]);
                r_xb[i]  <= r_xa[i];
                r_x2b[i] <= r_x2a[i];
                r_ngb[i] <= r_nga[i];
            end
        end
    end

    assign w_sp = 62'(r_xb[N-1]) * 62'(r_tb[N-1]);

    // Final product and sign of the half turn
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_ngb[N-1]) begin
                r_sin <= -$signed(w_sp[61:30]);
            end else begin
                r_sin <= $signed(w_sp[61:30]);
            end
        end
    end

    assign o_sin = r_sin;

endmodule

>>> src/tlpp_rot.sv
// Rotation back end: scale by range, pan and tilt turns, mm output, intensity.
module tlpp_rot (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  tlpp_pkg::t_cfg                      i_cfg,
    input  logic [15:0]                         i_range,
    input  logic [15:0]                         i_raw,
    input  logic signed [tlpp_pkg::TRIG_W-1:0]  i_cos_th,
    input  logic signed [tlpp_pkg::TRIG_W-1:0]  i_sin_th,
    input  logic signed [tlpp_pkg::TRIG_W-1:0]  i_cos_psi,
    input  logic signed [tlpp_pkg::TRIG_W-1:0]  i_sin_psi,
    input  logic signed [tlpp_pkg::TRIG_W-1:0]  i_cos_tl,
    input  logic signed [tlpp_pkg::TRIG_W-1:0]  i_sin_tl,
    output logic signed [tlpp_pkg::COORD_W-1:0] o_x,
    output logic signed [tlpp_pkg::COORD_W-1:0] o_y,
    output logic signed [tlpp_pkg::COORD_W-1:0] o_z,
    output logic [15:0]                         o_int
);

    // Round by sh bits, halves away from zero
    function automatic logic signed [79:0] f_rnd(input logic signed [79:0] p, input int sh);
        logic signed [79:0] h;
        h = 80'sd1 <<< (sh - 1);
        return (p < 0) ? ((p + h - 80'sd1) >>> sh) : ((p + h) >>> sh);
    endfunction

    // Q16 to whole mm, saturated
    function automatic logic [tlpp_pkg::COORD_W-1:0] f_mm(input logic signed [34:0] q);
        logic signed [79:0] v;
        v = f_rnd(80'(q), 16);
        if (v > 80'sd65535) begin
            return 17'h0FFFF;
        end else if (v < -80'sd65536) begin
            return 17'h10000;
        end
        return v[16:0];
    endfunction

    logic signed [48:0] r_mxl, r_mzl;
    logic signed [31:0] r_cp1, r_sp1, r_ct1, r_st1;
    logic [15:0]        r_diff;
    logic signed [33:0] r_xl, r_zl;
    logic signed [31:0] r_cp2, r_sp2, r_ct2, r_st2;
    logic [39:0]        r_iprod;
    logic signed [65:0] r_mxs, r_mys;
    logic signed [33:0] r_zl3;
    logic signed [31:0] r_ct3, r_st3;
    logic [15:0]        r_int3;
    logic signed [33:0] r_xs, r_ys, r_zs;
    logic signed [31:0] r_ct4, r_st4;
    logic signed [65:0] r_m1, r_m2, r_m3, r_m4;
    logic signed [33:0] r_xs5;
    logic signed [33:0] r_a, r_b, r_c, r_d;
    logic signed [33:0] r_xs6;
    logic signed [34:0] r_yw, r_nzw;
    logic signed [33:0] r_xs7;
    logic [15:0]        r_idl [5];
    logic [tlpp_pkg::COORD_W-1:0] r_px, r_py, r_pz;
    logic [40:0]        w_isum;

    assign w_isum = 41'(r_iprod) + 41'd128;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Laser-plane point products, intensity offset
            r_mxl  <= $signed({1'b0, i_range}) * i_cos_th;
            r_mzl  <= $signed({1'b0, i_range}) * i_sin_th;
            r_cp1  <= i_cos_psi;
            r_sp1  <= i_sin_psi;
            r_ct1  <= i_cos_tl;
            r_st1  <= i_sin_tl;
            r_diff <= (i_raw > i_cfg.intensity_floor) ? (i_raw - i_cfg.intensity_floor)
                                                      : 16'd0;
            // Round to Q16 mm, intensity gain
            r_xl    <= 34'(f_rnd(80'(r_mxl), 14));
            r_zl    <= 34'(f_rnd(80'(r_mzl), 14));
            r_cp2   <= r_cp1;
            r_sp2   <= r_sp1;
            r_ct2   <= r_ct1;
            r_st2   <= r_st1;
            r_iprod <= 40'(r_diff) * 40'(i_cfg.intensity_gain);
            // Pan products, intensity round and clamp
            r_mxs <= 66'(r_xl) * 66'(r_cp2);
            r_mys <= 66'(r_xl) * 66'(r_sp2);
            r_zl3 <= r_zl;
            r_ct3 <= r_ct2;
            r_st3 <= r_st2;
            r_int3 <= (|w_isum[40:24]) ? 16'hFFFF : w_isum[23:8];
            // Round pan results
            r_xs  <= 34'(f_rnd(80'(r_mxs), 30));
            r_ys  <= 34'(f_rnd(80'(r_mys), 30));
            r_zs  <= r_zl3;
            r_ct4 <= r_ct3;
            r_st4 <= r_st3;
            // Tilt products
            r_m1  <= 66'(r_ct4) * 66'(r_ys);
            r_m2  <= 66'(r_st4) * 66'(r_zs);
            r_m3  <= 66'(r_st4) * 66'(r_ys);
            r_m4  <= 66'(r_ct4) * 66'(r_zs);
            r_xs5 <= r_xs;
            // Round tilt products
            r_a   <= 34'(f_rnd(80'(r_m1), 30));
            r_b   <= 34'(f_rnd(80'(r_m2), 30));
            r_c   <= 34'(f_rnd(80'(r_m3), 30));
            r_d   <= 34'(f_rnd(80'(r_m4), 30));
            r_xs6 <= r_xs5;
            // World y and negated world z
            r_yw  <= 35'(r_a) - 35'(r_b);
            r_nzw <= -35'(r_c) - 35'(r_d);
            r_xs7 <= r_xs6;
            // Whole mm with saturation
            r_px <= f_mm(35'(r_xs7));
            r_py <= f_mm(r_nzw);
            r_pz <= f_mm(r_yw);
            // Carry intensity alongside
            r_idl[0] <= r_int3;
            for (int k = 1; k < 5; k++) begin
                r_idl[k] <= r_idl[k-1];
            end
        end
    end

    assign o_x   = $signed(r_px);
    assign o_y   = $signed(r_py);
    assign o_z   = $signed(r_pz);
    assign o_int = r_idl[4];

endmodule

>>> src/tilted_lidar_point_projection_top.sv
// Top level of the tilted lidar point projection pipeline.
//
// Takes one beam beat per clock and returns one point beat per clock when not
// held: one stage forms the beam, pan and tilt angles, the six sine pipelines
// (14 stages each, two per Horner term of the series) set most of the latency,
// and eight stages scale, rotate, round and saturate. The pipeline and the input
// are held only while a finished point waits on a stalled output. No clearing
// pass after reset. The user must write configuration over the APB port while
// no beat is in flight; the block does not enforce this.
`include "assert_macros.svh"

module tilted_lidar_point_projection_top #(
    parameter int MAX_BEAMS = tlpp_pkg::MAX_BEAMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [4:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [15:0]                         i_range_mm,
    input  logic [15:0]                         i_raw_intensity,
    input  logic [9:0]                          i_beam_index,
    input  logic signed [15:0]                  i_motor_angle,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [tlpp_pkg::COORD_W-1:0] o_point_x,
    output logic signed [tlpp_pkg::COORD_W-1:0] o_point_y,
    output logic signed [tlpp_pkg::COORD_W-1:0] o_point_z,
    output logic [15:0]                         o_norm_intensity
);

    localparam int          LAT     = 1 + tlpp_pkg::SIN_LAT + tlpp_pkg::ROT_LAT;
    localparam int          SL      = tlpp_pkg::SIN_LAT;
    localparam int unsigned IDX_MAX = MAX_BEAMS - 1;

    tlpp_pkg::t_cfg w_cfg;
    logic           w_en;
    logic [LAT-1:0] r_vld;

    logic [9:0]                    n_idx;
    logic [33:0]                   w_step_prod;
    logic [tlpp_pkg::ANG_W-1:0]    n_th, n_psi, n_tilt;
    logic [tlpp_pkg::ANG_W-1:0]    r_th, r_th_c, r_psi, r_psi_c, r_tilt, r_tilt_c;
    logic [15:0]                   r_rng, r_raw;
    logic [15:0]                   r_rng_d [SL];
    logic [15:0]                   r_raw_d [SL];

    logic signed [tlpp_pkg::TRIG_W-1:0] w_sin_th, w_cos_th, w_sin_psi, w_cos_psi;
    logic signed [tlpp_pkg::TRIG_W-1:0] w_sin_tl, w_cos_tl;

    tlpp_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Advance unless a finished point waits on a stalled output
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // Form beam, pan and tilt angles
    always_comb begin
        n_idx       = (32'(i_beam_index) > IDX_MAX) ? 10'(IDX_MAX) : i_beam_index;
        w_step_prod = 34'(n_idx) * 34'(w_cfg.angle_step);
        n_th        = w_cfg.start_angle + w_step_prod[23:0];
        n_psi       = {w_cfg.pan_offset - $unsigned(i_motor_angle), 8'h00};
        n_tilt      = {w_cfg.tilt_angle, 8'h00};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_th     <= n_th;
            r_th_c   <= n_th + tlpp_pkg::QUARTER;
            r_psi    <= n_psi;
            r_psi_c  <= n_psi + tlpp_pkg::QUARTER;
            r_tilt   <= n_tilt;
            r_tilt_c <= n_tilt + tlpp_pkg::QUARTER;
            r_rng    <= i_range_mm;
            r_raw    <= i_raw_intensity;
            // Hold range and intensity level with the sine pipelines
            r_rng_d[0] <= r_rng;
            r_raw_d[0] <= r_raw;
            for (int k = 1; k < SL; k++) begin
                r_rng_d[k] <= r_rng_d[k-1];
                r_raw_d[k] <= r_raw_d[k-1];
            end
        end
    end

    tlpp_sin u_sin_th  (.i_clk(i_clk), .i_en(w_en), .i_angle(r_th),     .o_sin(w_sin_th));
    tlpp_sin u_cos_th  (.i_clk(i_clk), .i_en(w_en), .i_angle(r_th_c),   .o_sin(w_cos_th));
    tlpp_sin u_sin_psi (.i_clk(i_clk), .i_en(w_en), .i_angle(r_psi),    .o_sin(w_sin_psi));
    tlpp_sin u_cos_psi (.i_clk(i_clk), .i_en(w_en), .i_angle(r_psi_c),  .o_sin(w_cos_psi));
    tlpp_sin u_sin_tl  (.i_clk(i_clk), .i_en(w_en), .i_angle(r_tilt),   .o_sin(w_sin_tl));
    tlpp_sin u_cos_tl  (.i_clk(i_clk), .i_en(w_en), .i_angle(r_tilt_c), .o_sin(w_cos_tl));

    tlpp_rot u_rot (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_cfg     (w_cfg),
        .i_range   (r_rng_d[SL-1]),
        .i_raw     (r_raw_d[SL-1]),
        .i_cos_th  (w_cos_th),
        .i_sin_th  (w_sin_th),
        .i_cos_psi (w_cos_psi),
        .i_sin_psi (w_sin_psi),
        .i_cos_tl  (w_cos_tl),
        .i_sin_tl  (w_sin_tl),
        .o_x       (o_point_x),
        .o_y       (o_point_y),
        .o_z       (o_point_z),
        .o_int     (o_norm_intensity)
    );

    // Pipeline bookkeeping checks
    `ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0], "accepted beat lost")
    `ASSERT_NEXT(a_freeze_holds, i_clk, i_rst_n, !w_en, $stable(r_vld), "valid chain moved in stall")
    `ASSERT_NEXT(a_chain_shift, i_clk, i_rst_n, w_en, o_valid == $past(r_vld[LAT-2]), "valid chain skew")

endmodule

>>> tb/sv/tlpp_tb_pkg.sv
// Testbench types and register map of the tilted lidar point projection.
`timescale 1ns / 100ps
package tlpp_tb_pkg;

    // Register indexes on the APB port (byte address is 4 * index)
    typedef enum logic [2:0] {
        REG_START_ANGLE     = 3'd0,
        REG_ANGLE_STEP      = 3'd1,
        REG_PAN_OFFSET      = 3'd2,
        REG_TILT_ANGLE      = 3'd3,
        REG_INTENSITY_FLOOR = 3'd4,
        REG_INTENSITY_GAIN  = 3'd5,
        REG_UNUSED          = 3'd6
    } t_reg_index;

    typedef struct packed {
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] z;
        logic [15:0]        intensity;
    } t_point;

endpackage

>>> tb/sv/tlpp_point_checker.sv
// Checker that predicts each projected point and compares it with the block output.
`timescale 1ns / 100ps
module tlpp_point_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic [15:0]        i_range_mm,
    input  logic [15:0]        i_raw_intensity,
    input  logic [9:0]         i_beam_index,
    input  logic signed [15:0] i_motor_angle,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [16:0] o_point_x,
    input  logic signed [16:0] o_point_y,
    input  logic signed [16:0] o_point_z,
    input  logic [15:0]        o_norm_intensity,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int BEAM_LIMIT = 1024;

    logic [23:0] start_angle;
    logic [23:0] angle_step;
    logic [15:0] pan_offset;
    logic [15:0] tilt_angle;
    logic [15:0] intensity_floor;
    logic [23:0] intensity_gain;

    tlpp_tb_pkg::t_point expected_points[$];

    // Q30 sine of a 24-bit angle: quarter-wave fold and truncating Horner series
    function automatic longint sine_q30(logic [23:0] ang);
        longint unsigned divs[5] = '{110, 72, 42, 20, 6};
        longint unsigned u, x, x2, t, s;
        u = ang[21:0];
        if (ang[22])
            u = 64'h40_0000 - u;
        x = (u * 64'd6746518852) >> 24;
        x2 = (x * x) >> 30;
        t = 64'd1 << 30;
        for (int k = 0; k < 5; k++)
            t = (64'd1 << 30) - ((x2 * t) >> 30) / divs[k];
        s = (x * t) >> 30;
        return ang[23] ? -longint'(s) : longint'(s);
    endfunction

    function automatic longint cosine_q30(logic [23:0] ang);
        return sine_q30(ang + 24'h40_0000);
    endfunction

    // Signed product rounded by sh bits, halves away from zero
    function automatic longint round_mul(longint a, longint b, int sh);
        longint unsigned ma, mb, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        p = ma * mb;
        if (sh > 0)
            p = (p + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic signed [16:0] q16_to_mm(longint q16);
        longint v;
        v = round_mul(q16, 1, 16);
        if (v > 65535)
            v = 65535;
        if (v < -65536)
            v = -65536;
        return 17'(v);
    endfunction

    function automatic tlpp_tb_pkg::t_point project_beam(logic [15:0] range_mm,
                                                         logic [15:0] raw,
                                                         logic [9:0] index,
                                                         logic [15:0] motor);
        tlpp_tb_pkg::t_point p;
        longint unsigned idx, inten;
        logic [23:0] th, psi, tilt;
        longint r, xl, zl, xs, ys, ct, st, yw, zw;
        idx = index;
        if (idx > BEAM_LIMIT - 1)
            idx = BEAM_LIMIT - 1;
        th = 24'(longint'(start_angle) + idx * angle_step);
        psi = {16'(pan_offset - motor), 8'h00};
        tilt = {tilt_angle, 8'h00};
        r = range_mm;
        xl = round_mul(r, cosine_q30(th), 14);
        zl = round_mul(r, sine_q30(th), 14);
        xs = round_mul(xl, cosine_q30(psi), 30);
        ys = round_mul(xl, sine_q30(psi), 30);
        ct = cosine_q30(tilt);
        st = sine_q30(tilt);
        yw = round_mul(ct, ys, 30) - round_mul(st, zl, 30);
        zw = round_mul(st, ys, 30) + round_mul(ct, zl, 30);
        if (raw <= intensity_floor) begin
            inten = 0;
        end else begin
            inten = ((longint'(raw - intensity_floor)) * intensity_gain + 128) >> 8;
            if (inten > 65535)
                inten = 65535;
        end
        p.x = q16_to_mm(xs);
        p.y = q16_to_mm(-zw);
        p.z = q16_to_mm(yw);
        p.intensity = 16'(inten);
        return p;
    endfunction

    // Track registers, compare output beats, queue predictions for input beats
    always @(posedge i_clk) begin
        tlpp_tb_pkg::t_point want;
        if (!i_rst_n) begin
            start_angle     <= 24'd0;
            angle_step      <= 24'd16384;
            pan_offset      <= 16'd30037;
            tilt_angle      <= 16'(-5461);
            intensity_floor <= 16'd2000;
            intensity_gain  <= 24'd8389;
            o_errors = 0;
            expected_points.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (tlpp_tb_pkg::t_reg_index'(paddr[4:2]))
                    tlpp_tb_pkg::REG_START_ANGLE:     start_angle     <= pwdata[23:0];
                    tlpp_tb_pkg::REG_ANGLE_STEP:      angle_step      <= pwdata[23:0];
                    tlpp_tb_pkg::REG_PAN_OFFSET:      pan_offset      <= pwdata[15:0];
                    tlpp_tb_pkg::REG_TILT_ANGLE:      tilt_angle      <= pwdata[15:0];
                    tlpp_tb_pkg::REG_INTENSITY_FLOOR: intensity_floor <= pwdata[15:0];
                    tlpp_tb_pkg::REG_INTENSITY_GAIN:  intensity_gain  <= pwdata[23:0];
                    default: ;
                endcase
            end
            if (o_valid && !i_stall) begin
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected point beat x=%0d y=%0d z=%0d i=%0d", $time,
                             o_point_x, o_point_y, o_point_z, o_norm_intensity);
                    o_errors++;
                end else begin
                    want = expected_points.pop_front();
                    if (o_point_x !== want.x) begin
                        $display("%0t: point_x expected %0d actual %0d", $time, want.x, o_point_x);
                        o_errors++;
                    end
                    if (o_point_y !== want.y) begin
                        $display("%0t: point_y expected %0d actual %0d", $time, want.y, o_point_y);
                        o_errors++;
                    end
                    if (o_point_z !== want.z) begin
                        $display("%0t: point_z expected %0d actual %0d", $time, want.z, o_point_z);
                        o_errors++;
                    end
                    if (o_norm_intensity !== want.intensity) begin
                        $display("%0t: norm_intensity expected %0d actual %0d", $time,
                                 want.intensity, o_norm_intensity);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !o_stall)
                expected_points.insert(expected_points.size(),
                                       project_beam(i_range_mm, i_raw_intensity,
                                                    i_beam_index, i_motor_angle));
        end
        o_pending = expected_points.size();
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the testbench: clock, reset, register writes, beam stimulus and verdict.
`timescale 1ns / 100ps
module testbench;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel, penable, pwrite, pready;
    logic [4:0]         paddr;
    logic [31:0]        pwdata, prdata;
    logic               i_valid, o_stall, o_valid, i_stall;
    logic [15:0]        i_range_mm, i_raw_intensity;
    logic [9:0]         i_beam_index;
    logic signed [15:0] i_motor_angle;
    logic signed [16:0] o_point_x, o_point_y, o_point_z;
    logic [15:0]        o_norm_intensity;
    int                 errors, pending;
    int                 long_holds;
    bit                 sender_quiet, receiver_quiet;
    logic [15:0]        cur_floor;

    tilted_lidar_point_projection_top dut (.*);

    tlpp_point_checker checker_i (
        .*,
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic write_reg(tlpp_tb_pkg::t_reg_index idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_all(logic [23:0] start, logic [23:0] step, logic [15:0] pan,
                             logic [15:0] tilt, logic [15:0] floor_v, logic [23:0] gain);
        write_reg(tlpp_tb_pkg::REG_START_ANGLE, 32'(start));
        write_reg(tlpp_tb_pkg::REG_ANGLE_STEP, 32'(step));
        write_reg(tlpp_tb_pkg::REG_PAN_OFFSET, 32'(pan));
        write_reg(tlpp_tb_pkg::REG_TILT_ANGLE, 32'(tilt));
        write_reg(tlpp_tb_pkg::REG_INTENSITY_FLOOR, 32'(floor_v));
        write_reg(tlpp_tb_pkg::REG_INTENSITY_GAIN, 32'(gain));
        cur_floor = floor_v;
    endtask

    // Offer one beam beat, hold it until accepted, then idle for gap cycles
    task automatic send_beam(logic [15:0] rng, logic [15:0] raw, logic [9:0] idx,
                             logic [15:0] motor, int gap);
        i_valid         <= 1'b1;
        i_range_mm      <= rng;
        i_raw_intensity <= raw;
        i_beam_index    <= idx;
        i_motor_angle   <= motor;
        do @(posedge i_clk); while (o_stall);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int count);
        logic [15:0] rng, raw;
        for (int n = 0; n < count; n++) begin
            if (n % 50 == 0)
                sender_quiet = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       rng = 16'hFFFF;
                1:       rng = 16'd0;
                2:       rng = 16'($urandom_range(0, 255));
                default: rng = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0:       raw = cur_floor + 16'($urandom_range(0, 3)) - 16'd1;
                1:       raw = 16'hFFFF;
                default: raw = 16'($urandom);
            endcase
            send_beam(rng, raw, 10'($urandom), 16'($urandom),
                      sender_quiet ? 0 : $urandom_range(0, 14));
        end
    endtask

    // Drop valid, wait for every owed point, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Receiver: random stall per beat, with a long hold on request
    initial begin
        int seen_holds;
        int n;
        seen_holds = 0;
        i_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_holds != seen_holds) begin
                seen_holds = long_holds;
                n = 300;
            end else begin
                if ($urandom_range(0, 40) == 0)
                    receiver_quiet = ~receiver_quiet;
                n = receiver_quiet ? 0 : $urandom_range(0, 14);
            end
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    // Stimulus
    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_valid = 0; i_range_mm = '0; i_raw_intensity = '0; i_beam_index = '0;
        i_motor_angle = '0; long_holds = 0; sender_quiet = 0; receiver_quiet = 0;
        cur_floor = 16'd2000;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beams under reset settings
        send_beam(16'd0, 16'd0, 10'd0, 16'd0, 0);
        send_beam(16'hFFFF, 16'hFFFF, 10'd1023, 16'h8000, 1);
        send_beam(16'hFFFF, 16'd2000, 10'd0, 16'h7FFF, 0);
        send_beam(16'd1000, 16'd2001, 10'd1, 16'd30037, 2);
        send_beam(16'hFFFF, 16'd1999, 10'd512, 16'hFFFF, 0);
        send_beam(16'd4000, 16'd6000, 10'd256, 16'h8AAB, 0);
        send_beam(16'hFFFF, 16'd9000, 10'd768, 16'h0001, 3);
        send_beam(16'h5555, 16'hAAAA, 10'h155, 16'h5555, 0);
        send_beam(16'hAAAA, 16'h5555, 10'h2AA, 16'hAAAA, 0);
        drain();

        // Extremes: full-turn wrap of the beam angle, full gain, zero floor
        write_all(24'h80_0000, 24'hFF_FFFF, 16'h8000, 16'h7FFF, 16'd0, 24'hFF_FFFF);
        write_reg(tlpp_tb_pkg::REG_UNUSED, 32'hFFFF_FFFF);
        send_beam(16'hFFFF, 16'hFFFF, 10'd1023, 16'h7FFF, 0);
        send_beam(16'hFFFF, 16'd0, 10'd0, 16'h8000, 0);
        send_beam(16'hFFFF, 16'd1, 10'd1, 16'h0000, 0);
        send_random(140);
        drain();

        write_all(24'h7F_FFFF, 24'd0, 16'h7FFF, 16'h8000, 16'hFFFF, 24'd0);
        send_beam(16'hFFFF, 16'hFFFF, 10'd1023, 16'h8000, 0);
        send_random(140);
        drain();

        // Receiver holds off while the sender keeps offering
        write_all(24'hA0_0000, 24'd16384, 16'd30037, 16'd0, 16'd2000, 24'd8389);
        long_holds++;
        for (int n = 0; n < 60; n++)
            send_beam(16'($urandom), 16'($urandom), 10'($urandom), 16'($urandom), 0);
        send_random(100);
        drain();
        send_random(60);
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            write_all(24'($urandom), 24'($urandom_range(0, 65535)), 16'($urandom),
                      16'($urandom), 16'($urandom_range(0, 8000)), 24'($urandom_range(0, 40000)));
            send_random(135);
            drain();
        end

        while (pending != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
